### rtl/fseq_pkg.sv
// Shared types and constants for the flash erase and program sequencer.
// Holds the request and response payload structs, register index codes and constants.
// No dependencies.
package fseq_pkg;

   // Register indexes of the configuration port.
   localparam logic [7:0] CSR_FLASH_BASE       = 8'd0;
   localparam logic [7:0] CSR_BANK0_END        = 8'd1;
   localparam logic [7:0] CSR_DUAL_BANK        = 8'd2;
   localparam logic [7:0] CSR_SECURITY_PROTECT = 8'd3;

   // Values after reset of the flash base and bank-zero end registers.
   localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;
   localparam logic [31:0] BANK0_END_RESET  = 32'h0808_0000;

   // Bytes programmed by one word write.
   localparam int WORD_BYTES = 4;

   // Action codes of a poll.
   localparam logic ACTION_ERASE = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic        action;
      logic [23:0] offset;
      logic [23:0] byte_count;
      logic [31:0] data_word;
      logic        bank_busy;
   } req_type;

   typedef struct packed {
      logic        done_res;
      logic        use_bank1;
      logic        unlock;
      logic        relock;
      logic        erase_start;
      logic        erase_clear;
      logic        program_word;
      logic        program_clear;
      logic [31:0] flash_address;
      logic [31:0] write_data;
      logic        mirror_address;
   } rsp_type;

endpackage

### rtl/flash_erase_program_sequencer.sv
// Flash erase and program sequencer, advanced one poll at a time.
// Depends on fseq_pkg for the payload structs, register indexes and constants.
//
// Usage: every transfer on the req_ channel is one poll of an erase or a write
// operation. A poll in idle latches the address, bank and byte count and asks
// for an unlock. Later polls wait out the busy bank, clear the enable bits,
// start page erases or program one 32-bit word each, and finally relock the
// bank and report done_res. Polling the other operation in mid-sequence drops
// the sequencer back to idle without a relock.
// Every poll produces exactly one transfer on the rsp_ channel. The result sits
// in an output register and is offered in the cycle after the poll is accepted.
// Throughput is one poll per cycle: the sequencer state is updated at the
// accepting edge by a single level of compare and add logic, and req_ready
// stays high as long as the output register is empty or is being drained in
// the same cycle. When the receiver stalls, the result is held and req_ready
// drops until it is taken. Configuration writes on the csr_ channel are always
// accepted outside reset; indexes beyond the register list are ignored. Reset
// puts the sequencer in idle with an empty output register and loads the
// configuration registers with their default values. While reset is high
// neither the req_ nor the csr_ channel accepts a transfer.
module flash_erase_program_sequencer #(
   parameter int BANK0_PAGE_BYTES = 2048,
   parameter int BANK1_PAGE_BYTES = 4096,
   parameter int LENGTH_BITS      = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fseq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fseq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [31:0]      csr_data
);

   // Sequencer phase codes; codes above the last one behave as idle.
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_ERASE_BUSY = 3'd1;
   localparam logic [2:0] PH_ERASE_PROG = 3'd2;
   localparam logic [2:0] PH_WRITE_BUSY = 3'd3;
   localparam logic [2:0] PH_WRITE_PROG = 3'd4;

   // The page size compare runs wide enough for both the count and the page.
   localparam int PAGE_MAX = (BANK0_PAGE_BYTES > BANK1_PAGE_BYTES) ?
                             BANK0_PAGE_BYTES : BANK1_PAGE_BYTES;
   localparam int PAGE_W   = $clog2(PAGE_MAX + 1);
   localparam int CMP_W    = ((LENGTH_BITS > PAGE_W) ? LENGTH_BITS : PAGE_W) + 1;

   // Configuration registers.
   logic [31:0] flash_base_ff, flash_base_in;
   logic [31:0] bank0_end_ff, bank0_end_in;
   logic        dual_bank_ff, dual_bank_in;
   logic        security_protect_ff, security_protect_in;

   // Sequencer state.
   logic [2:0]             phase_ff, phase_in;
   logic                   bank_one_ff, bank_one_in;
   logic [31:0]            cursor_ff, cursor_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   fseq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic csr_fire;

   // Helpers for the datapath.
   logic [31:0]            idle_addr;
   logic [31:0]            count_ext;
   logic [CMP_W-1:0]       page_ext;
   logic [CMP_W-1:0]       rem_ext;
   logic [CMP_W-1:0]       rem_diff;
   logic [31:0]            page_addr_step;

   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;

   // A new poll enters whenever the output register is free or drains now.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes.
   always_comb begin
      flash_base_in       = flash_base_ff;
      bank0_end_in        = bank0_end_ff;
      dual_bank_in        = dual_bank_ff;
      security_protect_in = security_protect_ff;
      if (csr_fire) begin
         case (csr_index)
            fseq_pkg::CSR_FLASH_BASE:       flash_base_in       = csr_data;
            fseq_pkg::CSR_BANK0_END:        bank0_end_in        = csr_data;
            fseq_pkg::CSR_DUAL_BANK:        dual_bank_in        = csr_data[0];
            fseq_pkg::CSR_SECURITY_PROTECT: security_protect_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Address and length arithmetic, all evaluated in parallel.
   assign idle_addr = flash_base_ff + {8'd0, req_data.offset};
   assign count_ext = {8'd0, req_data.byte_count};
   assign page_ext  = bank_one_ff ? CMP_W'(BANK1_PAGE_BYTES) : CMP_W'(BANK0_PAGE_BYTES);
   assign rem_ext   = CMP_W'(remaining_ff);
   assign rem_diff  = rem_ext - page_ext;
   assign page_addr_step = 32'(page_ext);

   // One poll: next state and the result, from the current state and payload.
   always_comb begin
      phase_in     = phase_ff;
      bank_one_in  = bank_one_ff;
      cursor_in    = cursor_ff;
      remaining_in = remaining_ff;
      rsp_data_in  = '0;

      case (phase_ff)
         PH_ERASE_BUSY, PH_ERASE_PROG, PH_WRITE_BUSY, PH_WRITE_PROG: begin
            if (req_data.action == fseq_pkg::ACTION_ERASE) begin
               if (phase_ff == PH_ERASE_BUSY) begin
                  if (!req_data.bank_busy) begin
                     rsp_data_in.erase_clear = 1'b1;
                     if (remaining_ff == '0) begin
                        rsp_data_in.relock   = 1'b1;
                        rsp_data_in.done_res = 1'b1;
                        phase_in             = PH_IDLE;
                     end else begin
                        phase_in = PH_ERASE_PROG;
                     end
                  end
               end else if (phase_ff == PH_ERASE_PROG) begin
                  if (remaining_ff != '0) begin
                     rsp_data_in.erase_start    = 1'b1;
                     rsp_data_in.flash_address  = cursor_ff;
                     rsp_data_in.mirror_address = bank_one_ff && security_protect_ff;
                     // The remaining length stops at zero instead of wrapping.
                     remaining_in = (rem_ext > page_ext) ?
                                    rem_diff[LENGTH_BITS-1:0] : '0;
                     cursor_in    = cursor_ff + page_addr_step;
                  end
                  phase_in = PH_ERASE_BUSY;
               end else begin
                  // An erase poll in the middle of a write aborts it.
                  rsp_data_in.program_clear = (phase_ff == PH_WRITE_BUSY);
                  phase_in                  = PH_IDLE;
               end
            end else begin
               if (phase_ff == PH_WRITE_BUSY) begin
                  if (!req_data.bank_busy) begin
                     rsp_data_in.program_clear = 1'b1;
                     if (remaining_ff == '0) begin
                        rsp_data_in.relock   = 1'b1;
                        rsp_data_in.done_res = 1'b1;
                        phase_in             = PH_IDLE;
                     end else begin
                        phase_in = PH_WRITE_PROG;
                     end
                  end
               end else if (phase_ff == PH_WRITE_PROG) begin
                  if (remaining_ff != '0) begin
                     rsp_data_in.program_word  = 1'b1;
                     rsp_data_in.flash_address = cursor_ff;
                     rsp_data_in.write_data    = req_data.data_word;
                     // A final partial word finishes the count.
                     if (remaining_ff >= LENGTH_BITS'(fseq_pkg::WORD_BYTES)) begin
                        cursor_in    = cursor_ff + 32'(fseq_pkg::WORD_BYTES);
                        remaining_in = remaining_ff - LENGTH_BITS'(fseq_pkg::WORD_BYTES);
                     end else begin
                        remaining_in = '0;
                     end
                  end
                  phase_in = PH_WRITE_BUSY;
               end else begin
                  // A write poll in the middle of an erase aborts it.
                  rsp_data_in.erase_clear = (phase_ff == PH_ERASE_BUSY);
                  phase_in                = PH_IDLE;
               end
            end
         end
         default: begin
            // Idle: pick the bank, latch address and count, unlock.
            bank_one_in        = dual_bank_ff && (idle_addr >= bank0_end_ff);
            cursor_in          = idle_addr;
            remaining_in       = count_ext[LENGTH_BITS-1:0];
            rsp_data_in.unlock = 1'b1;
            phase_in = (req_data.action == fseq_pkg::ACTION_WRITE) ?
                       PH_WRITE_BUSY : PH_ERASE_BUSY;
         end
      endcase

      rsp_data_in.use_bank1 = bank_one_in;
   end

   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff       <= fseq_pkg::FLASH_BASE_RESET;
         bank0_end_ff        <= fseq_pkg::BANK0_END_RESET;
         dual_bank_ff        <= 1'b1;
         security_protect_ff <= 1'b0;
         phase_ff            <= PH_IDLE;
         bank_one_ff         <= 1'b0;
         cursor_ff           <= '0;
         remaining_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         flash_base_ff       <= flash_base_in;
         bank0_end_ff        <= bank0_end_in;
         dual_bank_ff        <= dual_bank_in;
         security_protect_ff <= security_protect_in;
         rsp_valid_ff        <= rsp_valid_in;
         if (req_fire) begin
            phase_ff     <= phase_in;
            bank_one_ff  <= bank_one_in;
            cursor_ff    <= cursor_in;
            remaining_ff <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A poll taken in idle always answers with an unlock.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == PH_IDLE) |=> rsp_valid && rsp_data.unlock)
      else $error("idle poll did not unlock");

   // At most one flash command besides the relock goes out per result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.unlock, rsp_data.erase_start, rsp_data.erase_clear,
                              rsp_data.program_word, rsp_data.program_clear}))
      else $error("more than one flash command in one result");

   // Completion always comes with a relock, and leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && rsp_data_in.done_res |=> rsp_data.relock && (phase_ff == PH_IDLE))
      else $error("done without relock or idle");

   // The address and data buses are quiet unless a command uses them.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.erase_start && !rsp_data.program_word |->
         (rsp_data.flash_address == '0) && (rsp_data.write_data == '0))
      else $error("address or data driven without a command");

endmodule

### bench/fseq_checker.sv
// Scoreboard for the flash erase and program sequencer: it watches the three channels,
// predicts the command set of every poll and compares it with the response transfers.
// Depends on fseq_pkg for the payload structs, register indexes and action codes.
module fseq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  fseq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  fseq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [31:0]       csr_data,
   output int                mismatch_count,
   output int                commands_outstanding,
   output int                completed_ops
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [23:0] BANK0_PAGE = 24'd2048;
   localparam logic [23:0] BANK1_PAGE = 24'd4096;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ERASE_WAIT,
      SEQ_ERASE_ISSUE,
      SEQ_WRITE_WAIT,
      SEQ_WRITE_ISSUE
   } seq_phase_type;

   logic [31:0]   base_addr;
   logic [31:0]   bank0_limit;
   logic          dual_bank_on;
   logic          protect_on;

   seq_phase_type phase;
   logic          bank_one;
   logic [31:0]   cursor;
   logic [23:0]   left_bytes;

   fseq_pkg::rsp_type expected_commands[$];

   // Works out the commands of one poll and advances the predicted sequencer state.
   function automatic fseq_pkg::rsp_type commands_for_poll(input fseq_pkg::req_type poll);
      fseq_pkg::rsp_type cmd;
      logic [31:0]       addr;
      logic [23:0]       page;
      cmd = '0;
      if (phase == SEQ_IDLE) begin
         addr       = base_addr + 32'(poll.offset);
         bank_one   = dual_bank_on && (addr >= bank0_limit);
         cursor     = addr;
         left_bytes = poll.byte_count;
         cmd.unlock = 1'b1;
         phase      = (poll.action == fseq_pkg::ACTION_WRITE) ?
                      SEQ_WRITE_WAIT : SEQ_ERASE_WAIT;
      end else if (poll.action == fseq_pkg::ACTION_ERASE) begin
         case (phase)
            SEQ_ERASE_WAIT: begin
               if (!poll.bank_busy) begin
                  cmd.erase_clear = 1'b1;
                  if (left_bytes == '0) begin
                     cmd.relock   = 1'b1;
                     cmd.done_res = 1'b1;
                     phase        = SEQ_IDLE;
                  end else begin
                     phase = SEQ_ERASE_ISSUE;
                  end
               end
            end
            SEQ_ERASE_ISSUE: begin
               if (left_bytes != '0) begin
                  page               = bank_one ? BANK1_PAGE : BANK0_PAGE;
                  cmd.erase_start    = 1'b1;
                  cmd.flash_address  = cursor;
                  cmd.mirror_address = bank_one && protect_on;
                  // The remaining length stops at zero instead of wrapping.
                  left_bytes         = (left_bytes > page) ? left_bytes - page : '0;
                  cursor             = cursor + 32'(page);
               end
               phase = SEQ_ERASE_WAIT;
            end
            default: begin
               // An erase poll aborts a write; only the wait phase clears the enable.
               cmd.program_clear = (phase == SEQ_WRITE_WAIT);
               phase             = SEQ_IDLE;
            end
         endcase
      end else begin
         case (phase)
            SEQ_WRITE_WAIT: begin
               if (!poll.bank_busy) begin
                  cmd.program_clear = 1'b1;
                  if (left_bytes == '0) begin
                     cmd.relock   = 1'b1;
                     cmd.done_res = 1'b1;
                     phase        = SEQ_IDLE;
                  end else begin
                     phase = SEQ_WRITE_ISSUE;
                  end
               end
            end
            SEQ_WRITE_ISSUE: begin
               if (left_bytes != '0) begin
                  cmd.program_word  = 1'b1;
                  cmd.flash_address = cursor;
                  cmd.write_data    = poll.data_word;
                  // A final partial word still gets programmed and ends the count.
                  if (left_bytes >= 24'(fseq_pkg::WORD_BYTES)) begin
                     cursor     = cursor + 32'(fseq_pkg::WORD_BYTES);
                     left_bytes = left_bytes - 24'(fseq_pkg::WORD_BYTES);
                  end else begin
                     left_bytes = '0;
                  end
               end
               phase = SEQ_WRITE_WAIT;
            end
            default: begin
               cmd.erase_clear = (phase == SEQ_ERASE_WAIT);
               phase           = SEQ_IDLE;
            end
         endcase
      end
      cmd.use_bank1 = bank_one;
      return cmd;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      fseq_pkg::rsp_type want;
      if (reset) begin
         base_addr      = fseq_pkg::FLASH_BASE_RESET;
         bank0_limit    = fseq_pkg::BANK0_END_RESET;
         dual_bank_on   = 1'b1;
         protect_on     = 1'b0;
         phase          = SEQ_IDLE;
         bank_one       = 1'b0;
         cursor         = '0;
         left_bytes     = '0;
         mismatch_count = 0;
         completed_ops  = 0;
         expected_commands.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fseq_pkg::CSR_FLASH_BASE:       base_addr    = csr_data;
               fseq_pkg::CSR_BANK0_END:        bank0_limit  = csr_data;
               fseq_pkg::CSR_DUAL_BANK:        dual_bank_on = csr_data[0];
               fseq_pkg::CSR_SECURITY_PROTECT: protect_on   = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_commands.push_back(commands_for_poll(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               $error("response transfer with no poll waiting for it");
               mismatch_count++;
            end else begin
               want = expected_commands.pop_front();
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("use_bank1", want.use_bank1, rsp_data.use_bank1);
               check_field("unlock", want.unlock, rsp_data.unlock);
               check_field("relock", want.relock, rsp_data.relock);
               check_field("erase_start", want.erase_start, rsp_data.erase_start);
               check_field("erase_clear", want.erase_clear, rsp_data.erase_clear);
               check_field("program_word", want.program_word, rsp_data.program_word);
               check_field("program_clear", want.program_clear, rsp_data.program_clear);
               check_field("flash_address", want.flash_address, rsp_data.flash_address);
               check_field("write_data", want.write_data, rsp_data.write_data);
               check_field("mirror_address", want.mirror_address, rsp_data.mirror_address);
               if (want.done_res)
                  completed_ops++;
            end
         end
      end
      commands_outstanding <= expected_commands.size();
   end

endmodule

### bench/tb_flash_erase_program_sequencer.sv
// Top of the flash erase and program sequencer testbench: clock, reset, poll and
// register stimulus, response back-pressure and the final verdict.
// Depends on fseq_pkg, the sequencer RTL and the fseq_checker scoreboard.
module tb_flash_erase_program_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the register list; the block must ignore writes to them.
   localparam logic [7:0] CSR_UNMAPPED  = 8'hFF;
   localparam logic [7:0] CSR_PAST_LAST = 8'h04;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fseq_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fseq_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_index = '0;
   logic [31:0]       csr_data  = '0;

   int mismatch_count;
   int commands_outstanding;
   int completed_ops;

   // Copy of the register settings, used only to shape the stimulus so that
   // most sequences run exactly to their end.
   logic [31:0] cfg_base = fseq_pkg::FLASH_BASE_RESET;
   logic [31:0] cfg_end  = fseq_pkg::BANK0_END_RESET;
   logic        cfg_dual = 1'b1;

   // Idling controls shared between the sender and the receiver process.
   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit quiet_tail      = 1'b0;
   int hold_rsp_cycles = 0;

   int polls_sent     = 0;
   int settings_used  = 1;
   int leftover_fails = 0;

   flash_erase_program_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fseq_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data             (req_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_data             (rsp_data),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .commands_outstanding (commands_outstanding),
      .completed_ops        (completed_ops)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response receiver. It normally takes every result, stalls in short random
   // bursts while stalling is enabled, and once holds off for a long stretch so
   // that the output register fills up and the block pushes back on its polls.
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (hold_rsp_cycles > 0) begin
            hold            = hold_rsp_cycles;
            hold_rsp_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one poll and returns at the edge where its transfer happens. The
   // sender may first drop valid for a random burst of idle cycles; valid is
   // never lowered and raised again at the same edge.
   task automatic send_poll(input fseq_pkg::req_type poll);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= poll;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
   endtask

   task automatic poll(input logic act, input logic [23:0] off, input logic [23:0] cnt,
                       input logic [31:0] data, input logic busy);
      fseq_pkg::req_type p;
      p.action     = act;
      p.offset     = off;
      p.byte_count = cnt;
      p.data_word  = data;
      p.bank_busy  = busy;
      send_poll(p);
   endtask

   function automatic fseq_pkg::req_type random_poll();
      fseq_pkg::req_type p;
      p.action     = 1'($urandom);
      p.offset     = 24'($urandom);
      p.byte_count = 24'($urandom);
      p.data_word  = $urandom;
      p.bank_busy  = 1'($urandom);
      return p;
   endfunction

   // Offsets land anywhere, low in flash, or close to the end of bank zero.
   function automatic logic [23:0] pick_offset();
      logic [31:0] boundary;
      boundary = cfg_end - cfg_base;
      case ($urandom_range(0, 2))
         0:       return 24'($urandom);
         1:       return 24'($urandom_range(0, 16'hFFFF));
         default: return 24'(boundary) - 24'h2000 + 24'($urandom_range(0, 16'h3FFF));
      endcase
   endfunction

   task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_registers(input logic [31:0] base, input logic [31:0] bound,
                                input logic dual, input logic protect);
      write_reg(fseq_pkg::CSR_FLASH_BASE, base);
      write_reg(fseq_pkg::CSR_BANK0_END, bound);
      write_reg(fseq_pkg::CSR_DUAL_BANK, {31'($urandom), dual});
      write_reg(fseq_pkg::CSR_SECURITY_PROTECT, {31'($urandom), protect});
      cfg_base = base;
      cfg_end  = bound;
      cfg_dual = dual;
      settings_used++;
   endtask

   // Lets every poll in flight come back, so that the sequencer is idle before
   // registers change or the run ends.
   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (commands_outstanding != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // One erase or write operation. The poll count is worked out from the byte
   // count and the page size of the bank, so a well-formed sequence ends with
   // the done poll and leaves the sequencer idle. Busy polls are inserted only
   // where the sequencer waits on the bank, since they do not advance it there.
   // A broken sequence stops early and is aborted by a poll of the other kind.
   task automatic run_sequence();
      logic              act;
      logic [23:0]       off;
      logic [23:0]       cnt;
      int                page;
      int                steps;
      int                cut;
      int                k;
      bit                broken;
      fseq_pkg::req_type p;
      act = 1'($urandom);
      off = pick_offset();
      if ($urandom_range(0, 15) == 0)
         cnt = 24'($urandom);
      else if (act == fseq_pkg::ACTION_WRITE)
         cnt = 24'($urandom_range(0, 40));
      else
         cnt = 24'($urandom_range(0, 12288));
      if (act == fseq_pkg::ACTION_WRITE)
         page = fseq_pkg::WORD_BYTES;
      else if (cfg_dual && (cfg_base + 32'(off)) >= cfg_end)
         page = 4096;
      else
         page = 2048;
      steps  = 2 * ((int'(cnt) + page - 1) / page) + 1;
      broken = ($urandom_range(0, 5) == 0) || (steps > 80);
      cut    = broken ? $urandom_range(0, (steps > 80) ? 80 : steps - 1) : steps;

      p            = random_poll();
      p.action     = act;
      p.offset     = off;
      p.byte_count = cnt;
      send_poll(p);
      k = 0;
      while (k < cut) begin
         p        = random_poll();
         p.action = act;
         // Even steps are the bank wait phases; odd steps ignore the busy flag.
         if (k % 2 == 0)
            p.bank_busy = ($urandom_range(0, 3) == 0);
         send_poll(p);
         if (!(k % 2 == 0 && p.bank_busy))
            k++;
      end
      if (broken) begin
         p        = random_poll();
         p.action = ~act;
         send_poll(p);
      end
   endtask

   task automatic run_phase(input int target);
      int start;
      start = polls_sent;
      while (polls_sent - start < target) begin
         if (!quiet_tail && $urandom_range(0, 7) == 0)
            sender_gaps = ~sender_gaps;
         if (!quiet_tail && $urandom_range(0, 7) == 0)
            receiver_stalls = ~receiver_stalls;
         run_sequence();
      end
      drain();
   endtask

   initial begin
      logic [31:0] rand_base;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed polls with the registers at their reset values. Every transfer
      // here is one poll; the comments give the sequencer's reaction.
      // Erase of zero bytes: unlock, one busy wait, then clear, relock and done.
      poll(fseq_pkg::ACTION_ERASE, 24'h000000, 24'h000000, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h000000, 24'h000000, 32'h0000_0000, 1'b1);
      poll(fseq_pkg::ACTION_ERASE, 24'h000000, 24'h000000, 32'h0000_0000, 1'b0);
      // Write with all fields at their maximum on bank one, one word programmed,
      // then an erase poll in the write wait phase clears the enable and aborts.
      poll(fseq_pkg::ACTION_WRITE, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
      poll(fseq_pkg::ACTION_WRITE, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
      poll(fseq_pkg::ACTION_ERASE, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
      // One byte erased on the last bank-zero page: the count saturates at zero.
      poll(fseq_pkg::ACTION_ERASE, 24'h07F800, 24'h000001, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h07F800, 24'h000001, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h07F800, 24'h000001, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h07F800, 24'h000001, 32'h0000_0000, 1'b0);
      // Three-byte write at the start of bank one: the partial word ends the count.
      poll(fseq_pkg::ACTION_WRITE, 24'h080000, 24'h000003, 32'h1234_5678, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h080000, 24'h000003, 32'h1234_5678, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h080000, 24'h000003, 32'hA5A5_A5A5, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h080000, 24'h000003, 32'h0000_0000, 1'b1);
      poll(fseq_pkg::ACTION_WRITE, 24'h080000, 24'h000003, 32'h0000_0000, 1'b0);
      // Erase poll while a word is due: back to idle with no command at all.
      poll(fseq_pkg::ACTION_WRITE, 24'h000100, 24'h000008, 32'h5A5A_5A5A, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h000100, 24'h000008, 32'h5A5A_5A5A, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h000100, 24'h000008, 32'h5A5A_5A5A, 1'b0);
      // Write poll while the erase waits on the bank: clear the erase enable.
      poll(fseq_pkg::ACTION_ERASE, 24'h001000, 24'd5000, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h001000, 24'd5000, 32'h0000_0000, 1'b0);
      // Write poll while a page erase is due: back to idle silently.
      poll(fseq_pkg::ACTION_ERASE, 24'h000100, 24'd100, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_ERASE, 24'h000100, 24'd100, 32'h0000_0000, 1'b0);
      poll(fseq_pkg::ACTION_WRITE, 24'h000100, 24'd100, 32'h0000_0000, 1'b0);
      drain();

      // Zero base with protection on, so bank-one erases also mirror the address.
      // The receiver holds off at the start to fill the block and stall polls.
      set_registers(32'h0000_0000, 32'h0008_0000, 1'b1, 1'b1);
      write_reg(CSR_UNMAPPED, $urandom);
      hold_rsp_cycles = 80;
      run_phase(290);

      // Everything at the top: addresses wrap and only offset zero lands in bank one.
      set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      run_phase(290);

      // Single-bank flash with bank zero ending at address zero.
      set_registers(32'hFFFF_F000, 32'h0000_0000, 1'b0, 1'b0);
      write_reg(CSR_PAST_LAST, $urandom);
      run_phase(290);

      // Dual bank with every address in bank one and cursors that wrap.
      set_registers(32'hFFFF_C000, 32'h0000_0000, 1'b1, 1'b1);
      run_phase(290);

      // Random placement of the bank boundary within reach of the offsets.
      rand_base = $urandom;
      set_registers(rand_base, rand_base + 32'($urandom_range(0, 24'hFFFFFF)),
                    1'($urandom), 1'($urandom));
      run_phase(290);

      // Default map with protection on, and no idling on either side.
      quiet_tail      = 1'b1;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      set_registers(fseq_pkg::FLASH_BASE_RESET, fseq_pkg::BANK0_END_RESET, 1'b1, 1'b1);
      run_phase(260);

      if (commands_outstanding != 0) begin
         $error("%0d polls never got a response", commands_outstanding);
         leftover_fails++;
      end

      $display("Run covered %0d polls under %0d register settings,", polls_sent,
               settings_used);
      $display("with %0d erase and write operations carried through to done.",
               completed_ops);
      if (mismatch_count == 0 && leftover_fails == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
